@@ hdl/xpsd_pkg.sv @@
// shared constants, types and marker table for the xor pair stream decoder
package xpsd_pkg;

  // marker and header layout
  localparam logic [2:0] MARK_LEN         = 3'd5;
  localparam logic [5:0] KEY_OFFSET       = 6'd17;
  localparam logic [5:0] SKIP_AFTER_KEY   = 6'd42;
  localparam logic [5:0] FIRST_OUT_OFFSET = KEY_OFFSET + 6'd1 + SKIP_AFTER_KEY;
  localparam logic [7:0] FIRST_MASK       = 8'h43;
  localparam logic [1:0] ZERO_LIMIT       = 2'd2;
  localparam logic [7:0] NEWLINE          = 8'h0A;

  // results caused by one input transfer
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] byte0;
    logic       last0;
    logic [7:0] byte1;
    logic       last1;
  } xpsd_res_t;

  // marker byte at a given match position
  function automatic logic [7:0] marker_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h32;
      3'd1:    val = 8'h26;
      3'd2:    val = 8'h85;
      3'd3:    val = 8'h92;
      3'd4:    val = 8'h58;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

@@ hdl/xpsd_core.sv @@
// decode state and per-byte decode logic
module xpsd_core import xpsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       end_of_buffer,
  output xpsd_res_t  res
);

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_HEADER = 2'd1,
    PH_PAIRS  = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [2:0] match_r, match_nxt;
  logic [5:0] offset_r, offset_nxt;
  logic [7:0] key_r, key_nxt;
  logic [7:0] held_r, held_nxt;
  logic       half_r, half_nxt;
  logic [1:0] zeros_r, zeros_nxt;
  logic [7:0] decoded;
  logic [2:0] match_cur;

  // next state and results for the byte on the input
  always_comb begin
    phase_nxt  = phase_r;
    match_nxt  = match_r;
    offset_nxt = offset_r;
    key_nxt    = key_r;
    held_nxt   = held_r;
    half_nxt   = half_r;
    zeros_nxt  = zeros_r;
    res        = '0;
    decoded    = held_r ^ data_byte ^ key_r;
    match_cur  = '0;
    case (phase_r)
      PH_HEADER: begin
        offset_nxt = offset_r + 6'd1;
        if (offset_nxt == KEY_OFFSET) begin
          key_nxt = data_byte;
        end else if (offset_nxt == FIRST_OUT_OFFSET) begin
          res.count = 2'd1;
          res.byte0 = data_byte ^ (FIRST_MASK | key_r);
          res.last0 = 1'b1;
          phase_nxt = PH_PAIRS;
          half_nxt  = 1'b0;
          zeros_nxt = 2'd0;
        end
      end
      PH_PAIRS: begin
        if (!half_r) begin
          held_nxt = data_byte;
          half_nxt = 1'b1;
        end else begin
          half_nxt = 1'b0;
          if (decoded != 8'h00) begin
            res.count = 2'd1;
            res.byte0 = decoded;
            res.last0 = 1'b1;
          end else if (zeros_r >= ZERO_LIMIT) begin
            // third zero: newline only, back to search
            res.count = 2'd1;
            res.byte0 = NEWLINE;
            res.last0 = 1'b1;
            phase_nxt = PH_SEARCH;
            match_nxt = 3'd0;
            zeros_nxt = 2'd0;
          end else begin
            res.count = 2'd2;
            res.byte0 = NEWLINE;
            res.last0 = 1'b0;
            res.byte1 = 8'h00;
            res.last1 = 1'b1;
            zeros_nxt = zeros_r + 2'd1;
          end
        end
      end
      default: begin
        // marker search, unused phase code restarts the matcher
        match_cur = (phase_r != PH_SEARCH || match_r >= MARK_LEN) ? 3'd0 : match_r;
        phase_nxt = PH_SEARCH;
        if (data_byte == marker_byte(match_cur)) begin
          match_nxt = match_cur + 3'd1;
        end else begin
          match_nxt = (data_byte == marker_byte(3'd0)) ? 3'd1 : 3'd0;
        end
        if (match_nxt == MARK_LEN) begin
          phase_nxt  = PH_HEADER;
          offset_nxt = 6'(MARK_LEN - 3'd1);
          match_nxt  = 3'd0;
        end
      end
    endcase
    // end of buffer clears everything after the byte is handled
    if (end_of_buffer) begin
      phase_nxt  = PH_SEARCH;
      match_nxt  = '0;
      offset_nxt = '0;
      key_nxt    = '0;
      held_nxt   = '0;
      half_nxt   = 1'b0;
      zeros_nxt  = '0;
    end
  end

  // state registers, updated once per input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEARCH;
      match_r  <= '0;
      offset_r <= '0;
      key_r    <= '0;
      held_r   <= '0;
      half_r   <= 1'b0;
      zeros_r  <= '0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      match_r  <= match_nxt;
      offset_r <= offset_nxt;
      key_r    <= key_nxt;
      held_r   <= held_nxt;
      half_r   <= half_nxt;
      zeros_r  <= zeros_nxt;
    end
  end

endmodule

@@ hdl/xor_pair_stream_decoder.sv @@
// xor pair stream decoder: top level with result queue
//
// Input channel: one raw byte per transfer (in_data_byte) with in_end_of_buffer
// marking the last byte of a buffer. Result channel: decoded bytes or inserted
// newlines on out_byte, with out_last_of_run set on the final result that an
// input byte causes. Both channels transfer when valid is high and stall low.
// Each input byte is decoded in the cycle it is taken and its zero, one or two
// results are written into a four-entry result queue. Results are registered in
// the queue before they reach the output.
// Throughput: one input byte per cycle while the receiver keeps up; a byte
// that causes two results needs an output transfer for each, so the queue
// absorbs the burst and in_stall rises when fewer than two entries are free.
// Reset (synchronous, rst_n low) empties the queue and returns the decoder to
// marker search. While out_stall is high the head result holds on the output
// and input transfers continue until fewer than two queue entries are free.
module xor_pair_stream_decoder import xpsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_buffer,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);

  xpsd_res_t  res;
  logic       take;
  logic       pop;
  logic [8:0] queue_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;

  assign take = in_valid && !in_stall;
  assign pop  = out_valid && !out_stall;

  xpsd_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .data_byte     (in_data_byte),
    .end_of_buffer (in_end_of_buffer),
    .res           (res)
  );

  // queue pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (take) begin
      wr_ptr_nxt = wr_ptr_r + res.count;
      count_nxt  = count_nxt + {1'b0, res.count};
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 2'd1;
      count_nxt  = count_nxt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // result storage, up to two writes per transfer
  always_ff @(posedge clk) begin
    if (take && res.count != 2'd0) begin
      queue_r[wr_ptr_r] <= {res.byte0, res.last0};
    end
    if (take && res.count == 2'd2) begin
      queue_r[wr_ptr_r + 2'd1] <= {res.byte1, res.last1};
    end
  end

  // output side
  assign in_stall        = count_r > 3'd2;
  assign out_valid       = count_r != 3'd0;
  assign out_byte        = queue_r[rd_ptr_r][8:1];
  assign out_last_of_run = queue_r[rd_ptr_r][0];

endmodule

@@ hdl/xpsd_checker.sv @@
// port-level checks for the xor pair stream decoder and their bind
module xpsd_checker import xpsd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last_of_run
);

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last_of_run))
    else $error("stalled result changed");

  // a zero result always ends the run of its input byte
  a_zero_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte == 8'h00 |-> out_last_of_run)
    else $error("zero result not marked last");

  // only an inserted newline is followed by another result of the same byte
  a_nonlast_newline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> out_byte == NEWLINE)
    else $error("non-final result is not a newline");

  // input backpressure only while results are queued
  a_stall_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty queue");

endmodule

bind xor_pair_stream_decoder xpsd_checker u_xpsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_last_of_run (out_last_of_run)
);
